/* design/psrl_pkg.sv */
// Shared types and constants for the per-slot request rate limiter.
// No dependencies.
package psrl_pkg;

    localparam int SLOTS   = 256;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [15:0] REQ_LIMIT_RST = 16'd240;
    localparam logic [7:0]  EXP_LIMIT_RST = 8'd4;
    localparam logic [31:0] WIN_LEN_RST   = 32'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REQUEST_LIMIT   = 2'd0,
        CFG_EXPENSIVE_LIMIT = 2'd1,
        CFG_WINDOW_LENGTH   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        VERDICT_OK   = 2'd0,
        VERDICT_RATE = 2'd1,
        VERDICT_COST = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [31:0] window_start;
        logic [15:0] request_count;
        logic [7:0]  expensive_count;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic read;
        logic update;
    } ctrl_cmd_t;

endpackage

/* design/psrl_ctrl.sv */
// Sequencer for the rate limiter: capture, entry read, update and write back.
// Depends on psrl_pkg.
module psrl_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output psrl_pkg::ctrl_cmd_t  cmd
);

    psrl_pkg::state_t state_reg;
    psrl_pkg::state_t state_next;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psrl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        busy        = 1'b0;
        cmd.read    = 1'b0;
        cmd.update  = 1'b0;
        unique case (state_reg)
            psrl_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = psrl_pkg::ST_READ;
                end
            end
            psrl_pkg::ST_READ:
            begin
                busy       = 1'b1;
                cmd.read   = 1'b1;
                state_next = psrl_pkg::ST_UPDATE;
            end
            psrl_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = start ? psrl_pkg::ST_READ : psrl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = psrl_pkg::ST_IDLE;
            end
        endcase
        accept      = start && !busy;
        cmd.capture = accept;
    end

    a_read_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |=> cmd.update)
        else $error("entry read not followed by update");

    a_update_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> !cmd.update)
        else $error("two updates in consecutive cycles");

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cmd.read)
        else $error("accepted beat not read");

endmodule

/* design/psrl_datapath.sv */
// Datapath: configuration registers, slot store with valid bits,
// window/count update and registered result. Depends on psrl_pkg.
module psrl_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  psrl_pkg::ctrl_cmd_t                cmd,
    input  logic [7:0]                         slot,
    input  logic [31:0]                        now_ms,
    input  logic                               is_expensive,
    input  logic                               cfg_wr_en,
    input  logic [psrl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psrl_pkg::CFG_W-1:0]         cfg_data,
    output logic                               done,
    output logic                               allowed,
    output logic [1:0]                         verdict
);

    logic [15:0] req_limit_reg;
    logic [7:0]  exp_limit_reg;
    logic [31:0] win_len_reg;

    logic [psrl_pkg::SLOT_W-1:0] idx_reg;
    logic [31:0]                 now_reg;
    logic                        exp_reg;

    psrl_pkg::entry_t mem [psrl_pkg::SLOTS];
    logic             valid_reg [psrl_pkg::SLOTS];
    psrl_pkg::entry_t rd_reg;
    logic             rd_valid_reg;

    psrl_pkg::entry_t  cur;
    psrl_pkg::entry_t  upd;
    logic [31:0]       elapsed;
    logic              restart;
    logic [15:0]       rc0;
    logic [7:0]        ec0;
    logic              rate_fail;
    logic              cost_fail;
    psrl_pkg::verdict_t verdict_next;

    logic               done_reg;
    logic               allowed_reg;
    psrl_pkg::verdict_t verdict_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_limit_reg <= psrl_pkg::REQ_LIMIT_RST;
            exp_limit_reg <= psrl_pkg::EXP_LIMIT_RST;
            win_len_reg   <= psrl_pkg::WIN_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                psrl_pkg::CFG_REQUEST_LIMIT:   req_limit_reg <= cfg_data[15:0];
                psrl_pkg::CFG_EXPENSIVE_LIMIT: exp_limit_reg <= cfg_data[7:0];
                psrl_pkg::CFG_WINDOW_LENGTH:   win_len_reg   <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg <= psrl_pkg::SLOT_W'(slot % psrl_pkg::SLOTS);
            now_reg <= now_ms;
            exp_reg <= is_expensive;
        end
    end

    // store read and write back
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_reg <= mem[idx_reg];
        end
        if (cmd.update)
        begin
            mem[idx_reg] <= upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < psrl_pkg::SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.read)
            begin
                rd_valid_reg <= valid_reg[idx_reg];
            end
            if (cmd.update)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        cur       = rd_valid_reg ? rd_reg : '0;
        elapsed   = now_reg - cur.window_start;
        restart   = elapsed >= win_len_reg;
        upd.window_start = restart ? now_reg : cur.window_start;
        rc0       = restart ? 16'd0 : cur.request_count;
        ec0       = restart ? 8'd0  : cur.expensive_count;
        upd.request_count = (rc0 == 16'hFFFF) ? rc0 : rc0 + 16'd1;
        rate_fail = upd.request_count > req_limit_reg;
        upd.expensive_count = ec0;
        cost_fail = 1'b0;
        if (!rate_fail && exp_reg)
        begin
            upd.expensive_count = (ec0 == 8'hFF) ? ec0 : ec0 + 8'd1;
            cost_fail = upd.expensive_count > exp_limit_reg;
        end
        if (rate_fail)
        begin
            verdict_next = psrl_pkg::VERDICT_RATE;
        end
        else if (cost_fail)
        begin
            verdict_next = psrl_pkg::VERDICT_COST;
        end
        else
        begin
            verdict_next = psrl_pkg::VERDICT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            allowed_reg <= (verdict_next == psrl_pkg::VERDICT_OK);
            verdict_reg <= verdict_next;
        end
    end

    assign done    = done_reg;
    assign allowed = allowed_reg;
    assign verdict = verdict_reg;

    a_done_follows_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.update))
        else $error("result beat without update");

    a_allowed_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (allowed == (verdict == psrl_pkg::VERDICT_OK)))
        else $error("allowed disagrees with verdict");

    a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> valid_reg[$past(idx_reg)])
        else $error("written entry not marked valid");

endmodule

/* design/per_slot_request_rate_limiter_top.sv */
// Top level of the per-slot fixed-window request rate limiter.
// Depends on psrl_pkg, psrl_ctrl and psrl_datapath.
//
//   channel   handshake              payload
//   request   start / busy           slot, now_ms, is_expensive
//   result    done (one-cycle beat)  allowed, verdict
//   config    cfg_wr_en              cfg_index, cfg_data
//
// A request runs through a registered read of the slot entry, then
// the update and write back of the same entry. A new beat is taken in the
// idle or update state, so the next request can enter during an update.
// The result beat appears the cycle after the update.
// Reset clears the per-slot valid bits at once; no clearing pass.
// Results cannot be stalled.
module per_slot_request_rate_limiter_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [7:0]                       slot,
    input  logic [31:0]                      now_ms,
    input  logic                             is_expensive,
    output logic                             done,
    output logic                             allowed,
    output logic [1:0]                       verdict,
    input  logic                             cfg_wr_en,
    input  logic [psrl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psrl_pkg::CFG_W-1:0]       cfg_data
);

    psrl_pkg::ctrl_cmd_t cmd;

    psrl_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    psrl_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .slot         (slot),
        .now_ms       (now_ms),
        .is_expensive (is_expensive),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .allowed      (allowed),
        .verdict      (verdict)
    );

endmodule

/* test/per_slot_request_rate_limiter_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for per_slot_request_rate_limiter_top: directed table, expensive-count
// saturation run and randomised phases; beats scored against table entries or a local predictor.
// Depends on psrl_pkg and the rate limiter RTL.
module per_slot_request_rate_limiter_top_tb;

    localparam int TIMEOUT_CYCLES = 4_000_000;
    localparam int WANT_DEPTH     = 16;

    localparam logic [psrl_pkg::CFG_IDX_W-1:0] REG_RL    = psrl_pkg::CFG_REQUEST_LIMIT;
    localparam logic [psrl_pkg::CFG_IDX_W-1:0] REG_EL    = psrl_pkg::CFG_EXPENSIVE_LIMIT;
    localparam logic [psrl_pkg::CFG_IDX_W-1:0] REG_WL    = psrl_pkg::CFG_WINDOW_LENGTH;
    localparam logic [psrl_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam psrl_pkg::verdict_t V_OK   = psrl_pkg::VERDICT_OK;
    localparam psrl_pkg::verdict_t V_RATE = psrl_pkg::VERDICT_RATE;
    localparam psrl_pkg::verdict_t V_COST = psrl_pkg::VERDICT_COST;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        logic               allowed;
        psrl_pkg::verdict_t verdict;
    } verdict_beat_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic [7:0]                     slot;
        logic [31:0]                    value;   // now_ms for requests, write data for registers
        logic                           costly;
        logic [psrl_pkg::CFG_IDX_W-1:0] addr;
        logic                           typed;
        verdict_beat_t                  want;
    } plan_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [7:0]                     slot = '0;
    logic [31:0]                    now_ms = '0;
    logic                           is_expensive = 1'b0;
    logic                           done;
    logic                           allowed;
    logic [1:0]                     verdict;
    logic                           cfg_wr_en = 1'b0;
    logic [psrl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [psrl_pkg::CFG_W-1:0]     cfg_data = '0;

    // predictor state and register copies
    logic [31:0] win_start [psrl_pkg::SLOTS];
    logic [15:0] req_count [psrl_pkg::SLOTS];
    logic [7:0]  cost_count [psrl_pkg::SLOTS];
    logic [15:0] req_limit = psrl_pkg::REQ_LIMIT_RST;
    logic [7:0]  cost_limit = psrl_pkg::EXP_LIMIT_RST;
    logic [31:0] win_len = psrl_pkg::WIN_LEN_RST;

    // expected beats in flight; written only by issue, read only by the monitor
    verdict_beat_t want_fifo [WANT_DEPTH];
    int unsigned   pushed = 0;
    int unsigned   popped = 0;
    int mismatches = 0;
    int burst_left = 0;

    plan_row_t directed_plan [0:27] = '{
        '{ROW_REQ, 8'd0,   32'h0000_0000, 1'b0, REG_RL,    1'b1, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd0,   32'h0000_03E7, 1'b1, REG_RL,    1'b1, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd255, 32'hFFFF_FFFF, 1'b1, REG_RL,    1'b1, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd255, 32'h0000_0000, 1'b1, REG_RL,    1'b1, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd255, 32'h0000_0005, 1'b1, REG_RL,    1'b1, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd255, 32'h0000_0005, 1'b1, REG_RL,    1'b1, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd255, 32'h0000_0005, 1'b1, REG_RL,    1'b1, '{1'b0, V_COST}},
        '{ROW_REQ, 8'd255, 32'h0000_03E8, 1'b1, REG_RL,    1'b1, '{1'b1, V_OK}},
        '{ROW_CFG, 8'd0,   32'h0000_0000, 1'b0, REG_EL,    1'b0, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd1,   32'h0000_000A, 1'b1, REG_RL,    1'b1, '{1'b0, V_COST}},
        '{ROW_REQ, 8'd1,   32'h0000_000A, 1'b0, REG_RL,    1'b1, '{1'b1, V_OK}},
        '{ROW_CFG, 8'd0,   32'hABCD_0000, 1'b0, REG_RL,    1'b0, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd2,   32'h0000_0000, 1'b1, REG_RL,    1'b1, '{1'b0, V_RATE}},
        '{ROW_CFG, 8'd0,   32'h0000_0002, 1'b0, REG_RL,    1'b0, '{1'b1, V_OK}},
        '{ROW_CFG, 8'd0,   32'h1234_56FF, 1'b0, REG_EL,    1'b0, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd3,   32'h0000_0032, 1'b1, REG_RL,    1'b1, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd3,   32'h0000_0032, 1'b1, REG_RL,    1'b1, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd3,   32'h0000_0032, 1'b1, REG_RL,    1'b1, '{1'b0, V_RATE}},
        '{ROW_CFG, 8'd0,   32'h0000_0000, 1'b0, REG_WL,    1'b0, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd3,   32'h0000_0032, 1'b1, REG_RL,    1'b1, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd3,   32'h0000_0032, 1'b1, REG_RL,    1'b1, '{1'b1, V_OK}},
        '{ROW_CFG, 8'd0,   32'h0000_0000, 1'b0, REG_SPARE, 1'b0, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd3,   32'h0000_0032, 1'b1, REG_RL,    1'b1, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd3,   32'h0000_0032, 1'b1, REG_RL,    1'b1, '{1'b1, V_OK}},
        '{ROW_CFG, 8'd0,   32'hFFFF_FFFF, 1'b0, REG_WL,    1'b0, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd4,   32'hFFFF_FFFE, 1'b1, REG_RL,    1'b0, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd4,   32'hFFFF_FFFF, 1'b0, REG_RL,    1'b0, '{1'b1, V_OK}},
        '{ROW_REQ, 8'd4,   32'h0000_0000, 1'b1, REG_RL,    1'b0, '{1'b1, V_OK}}
    };

    per_slot_request_rate_limiter_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .slot         (slot),
        .now_ms       (now_ms),
        .is_expensive (is_expensive),
        .done         (done),
        .allowed      (allowed),
        .verdict      (verdict),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic verdict_beat_t judge_request(logic [7:0] s, logic [31:0] t, logic x);
        int unsigned   k;
        logic [31:0]   elapsed;
        verdict_beat_t r;
        k = s % psrl_pkg::SLOTS;
        elapsed = t - win_start[k];
        r.allowed = 1'b1;
        r.verdict = psrl_pkg::VERDICT_OK;
        if (elapsed >= win_len)
        begin
            win_start[k] = t;
            req_count[k] = '0;
            cost_count[k] = '0;
        end
        if (req_count[k] != 16'hFFFF)
            req_count[k] = req_count[k] + 16'd1;
        if (req_count[k] > req_limit)
        begin
            r.allowed = 1'b0;
            r.verdict = psrl_pkg::VERDICT_RATE;
        end
        else if (x)
        begin
            if (cost_count[k] != 8'hFF)
                cost_count[k] = cost_count[k] + 8'd1;
            if (cost_count[k] > cost_limit)
            begin
                r.allowed = 1'b0;
                r.verdict = psrl_pkg::VERDICT_COST;
            end
        end
        return r;
    endfunction

    // drop start and let every outstanding verdict come back
    task automatic settle();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pushed != popped && waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [psrl_pkg::CFG_IDX_W-1:0] addr, logic [31:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= addr;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (addr)
            psrl_pkg::CFG_REQUEST_LIMIT:   req_limit = value[15:0];
            psrl_pkg::CFG_EXPENSIVE_LIMIT: cost_limit = value[7:0];
            psrl_pkg::CFG_WINDOW_LENGTH:   win_len = value;
            default:                       ;
        endcase
    endtask

    task automatic issue(logic [7:0] s, logic [31:0] t, logic x, logic typed,
                         verdict_beat_t typed_beat);
        verdict_beat_t beat;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
        end
        burst_left--;
        start        <= 1'b1;
        slot         <= s;
        now_ms       <= t;
        is_expensive <= x;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        beat = judge_request(s, t, x);
        want_fifo[pushed % WANT_DEPTH] = typed ? typed_beat : beat;
        pushed++;
    endtask

    always @(posedge clk)
    begin
        verdict_beat_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pushed == popped)
            begin
                if (mismatches < 10)
                    $display("unexpected beat: allowed %0b verdict %0d", allowed, verdict);
                mismatches++;
            end
            else
            begin
                want = want_fifo[popped % WANT_DEPTH];
                popped++;
                if (allowed !== want.allowed || verdict !== want.verdict)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected allowed %0b verdict %0d, got %0b / %0d",
                                 want.allowed, want.verdict, allowed, verdict);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        plan_row_t   row;
        logic [7:0]  hot [4];
        logic [7:0]  s;
        logic [31:0] stamp;
        logic [15:0] rl;
        logic [7:0]  el;
        logic [31:0] wl;
        int          pick;

        for (int i = 0; i < psrl_pkg::SLOTS; i++)
        begin
            win_start[i] = '0;
            req_count[i] = '0;
            cost_count[i] = '0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.kind == ROW_CFG)
                write_reg(row.addr, row.value);
            else
                issue(row.slot, row.value, row.costly, row.typed, row.want);
        end

        // drive one slot's expensive count into saturation within a single window
        write_reg(REG_RL, 32'h5A5A_FFFF);
        write_reg(REG_EL, 32'h1234_56FE);
        write_reg(REG_WL, 32'hFFFF_FFFF);
        for (int i = 0; i < 258; i++)
            issue(8'd7, 32'd12345, 1'b1, 1'b0, '0);
        write_reg(REG_EL, 32'hA5A5_A5FF);
        for (int i = 0; i < 8; i++)
            issue(8'd7, 32'd12345, 1'($urandom_range(0, 1)), 1'b0, '0);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin rl = 16'($urandom_range(1, 6)); el = 8'($urandom_range(0, 3));
                         wl = $urandom_range(1, 40); end
                1: begin rl = 16'd0; el = 8'($urandom); wl = $urandom_range(0, 65535); end
                2: begin rl = 16'hFFFF; el = 8'hFF; wl = 32'd0; end
                3: begin rl = 16'($urandom); el = 8'($urandom); wl = $urandom; end
                4: begin rl = 16'($urandom_range(3, 20)); el = 8'($urandom_range(1, 6));
                         wl = $urandom_range(50, 500); end
                5: begin rl = 16'hFFFE; el = 8'hFE; wl = 32'hFFFF_FFFF; end
                6: begin rl = 16'd1; el = 8'd0; wl = 32'd1; end
                default: begin rl = 16'($urandom_range(2, 10)); el = 8'($urandom_range(0, 5));
                               wl = $urandom_range(5, 100); end
            endcase
            write_reg(REG_RL, {16'($urandom), rl});
            write_reg(REG_EL, {24'($urandom), el});
            write_reg(REG_WL, wl);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE, $urandom);

            foreach (hot[i])
                hot[i] = 8'($urandom_range(0, 255));
            hot[0] = (phase % 2 == 0) ? 8'd0 : 8'd255;
            stamp = (phase % 2 == 1) ? 32'($urandom) : 32'($urandom_range(0, 500));

            for (int n = 0; n < 95; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    stamp = stamp + $urandom_range(0, 3);
                else if (pick < 90)
                    stamp = stamp + $urandom_range(0, 80);
                else if (pick < 98)
                    stamp = stamp + $urandom_range(0, 3000);
                else
                    stamp = $urandom;
                s = ($urandom_range(0, 4) != 0) ? hot[$urandom_range(0, 3)]
                                                : 8'($urandom_range(0, 255));
                issue(s, stamp, $urandom_range(0, 2) != 0, 1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0 && pushed == popped)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* per_slot_request_rate_limiter_top.f */
design/psrl_pkg.sv
design/psrl_ctrl.sv
design/psrl_datapath.sv
design/per_slot_request_rate_limiter_top.sv
test/per_slot_request_rate_limiter_top_tb.sv
